/* hw/rtl/gisd_pkg.sv */
// Package for the gyro impulse sequence detector: shared constants and types.
// Used by every module of the block; depends on nothing.
package gisd_pkg;

   localparam int TimeConstantMs   = 250;
   localparam int HeadQuietMs      = 300;
   localparam int ClickHoldoffMs   = 500;
   localparam int ImpulseHoldoffMs = 60;
   localparam int MaxStepMs        = 50;
   localparam int MinImpulses      = 2;

   localparam logic [2:0] CSR_ENTER    = 3'd0;
   localparam logic [2:0] CSR_EXIT     = 3'd1;
   localparam logic [2:0] CSR_HEAD     = 3'd2;
   localparam logic [2:0] CSR_IMP_MIN  = 3'd3;
   localparam logic [2:0] CSR_IMP_MAX  = 3'd4;
   localparam logic [2:0] CSR_GAP_MIN  = 3'd5;
   localparam logic [2:0] CSR_GAP_MAX  = 3'd6;
   localparam logic [2:0] CSR_NEEDED   = 3'd7;

   // Operation select for the shared multiply-accumulate unit.
   typedef enum logic [2:0] {
      MAC_CLEAR = 3'd0,
      MAC_SQ    = 3'd1,
      MAC_STEP  = 3'd2
   } mac_op_type;

   typedef struct packed {
      mac_op_type   op;
      logic [16:0]  a;   // unsigned operand
      logic [32:0]  b;   // signed operand
   } mac_cmd_type;

endpackage

/* hw/rtl/gisd_mac.sv */
// Shared multiply-accumulate unit of the gyro impulse sequence detector.
// Depends on gisd_pkg.
module gisd_mac
   import gisd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mac_cmd_type cmd,
   output logic [63:0] acc,
   output logic [49:0] prod
);
   logic [63:0] acc_ff, acc_in;
   logic [49:0] prod_ff;

   always_comb begin
      acc_in = acc_ff;
      case (cmd.op)
         MAC_CLEAR: acc_in = '0;
         MAC_SQ:    acc_in = acc_ff + 64'(signed'(cmd.b) * signed'(cmd.b));
         MAC_STEP:  acc_in = acc_ff;
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      prod_ff <= 50'(signed'({1'b0, cmd.a}) * signed'(cmd.b));
   end

   assign acc  = acc_ff;
   assign prod = prod_ff;
endmodule

/* hw/rtl/gyro_impulse_sequence_detector.sv */
// Top level of the gyro impulse sequence detector: handshakes, sequencer,
// baseline filter, alpha table and gate logic. Depends on gisd_pkg and gisd_mac.
//
//   channel | direction | ports
//   req     | in        | req_valid/req_ready, mode, now_time, rate_x/y/z
//   rsp     | out       | rsp_valid/rsp_ready, click, accepted_count, click_count
//   csr     | in        | csr_valid/csr_ready, csr_index, csr_data
//
// From request transfer to response, each of the three baseline steps takes
// a multiply state and an update state, the shared multiplier then forms six
// squares, one per cycle, and the decision state makes the decision. A rearm
// or a first sample goes straight to the result state. The request side is
// not ready from transfer until the result has been taken, and the next
// request can transfer in the cycle after that. Reset is synchronous, clears
// the sequencer and detector state and loads the register defaults. A stalled
// response holds the block in its result state.
module gyro_impulse_sequence_detector
   import gisd_pkg::*;
#(
   parameter int TIME_CONSTANT_MS   = TimeConstantMs,
   parameter int HEAD_QUIET_MS      = HeadQuietMs,
   parameter int CLICK_HOLDOFF_MS   = ClickHoldoffMs,
   parameter int IMPULSE_HOLDOFF_MS = ImpulseHoldoffMs,
   parameter int MAX_STEP_MS        = MaxStepMs
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [31:0]        req_now_time,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_click,
   output logic [31:0]        rsp_accepted_count,
   output logic [31:0]        rsp_click_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STEP  = 6'b000010,
      ST_UPD   = 6'b000100,
      ST_SQ    = 6'b001000,
      ST_DEC   = 6'b010000,
      ST_RSP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   // Configuration registers.
   logic [14:0] enter_ff, exit_ff, head_ff;
   logic [15:0] imp_min_ff, imp_max_ff, gap_min_ff, gap_max_ff;
   logic [3:0]  needed_ff;

   // Captured request.
   logic [31:0]        now_ff;
   logic signed [15:0] rate_ff [3];
   logic signed [23:0] base_ff [3];
   logic [16:0]        alpha_ff;
   logic [63:0]        rsq_ff;

   // Detector state.
   logic        bvalid_ff, in_imp_ff, recent_ff, mgate_ff, cgate_ff;
   logic [31:0] prior_ff, imp_start_ff, seq_last_ff, recent_t_ff, mtime_ff, ctime_ff;
   logic [3:0]  seq_cnt_ff;
   logic [31:0] imp_total_ff, click_total_ff;
   logic        click_ff;

   mac_cmd_type cmd;
   logic [63:0] acc;
   logic [49:0] prod;
   logic [1:0]  ax;
   logic [2:0]  sq_sel;

   logic accept;
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_RSP);
   assign rsp_click = click_ff;
   assign rsp_accepted_count = imp_total_ff;
   assign rsp_click_count    = click_total_ff;

   assign ax = cnt_ff[1:0];
   assign sq_sel = cnt_ff[2:0];

   // Clamped step and its alpha come from the timestamp difference.
   logic [31:0] elapsed;
   logic [7:0]  dt;
   assign elapsed = req_now_time - prior_ff;
   always_comb begin
      if (elapsed > 32'(MAX_STEP_MS)) dt = 8'(MAX_STEP_MS);
      else if (elapsed == '0)         dt = 8'd1;
      else                            dt = elapsed[7:0];
   end

   // Alpha in Q0.16 for every possible step, dt / (T + dt) rounded to nearest.
   // The table is fixed at elaboration from the time constant.
   logic [16:0] alpha_tab [256];
   for (genvar g = 0; g < 256; g++) begin : g_alpha
      localparam int Den = TIME_CONSTANT_MS + g;
      localparam logic [16:0] Alpha = 17'((g * 65536 + Den / 2) / Den);
      assign alpha_tab[g] = Alpha;
   end

   logic signed [32:0] diff;
   assign diff = 33'(signed'({rate_ff[ax], 8'd0})) - 33'(base_ff[ax]);

   // Operands for the shared unit.
   always_comb begin
      cmd.op = MAC_CLEAR;
      cmd.a  = alpha_ff;
      cmd.b  = diff;
      if (state_ff == ST_STEP) begin
         cmd.op = MAC_STEP;
      end else if (state_ff == ST_SQ) begin
         cmd.op = MAC_SQ;
         if (sq_sel < 3'd3) begin
            cmd.b = 33'(signed'({rate_ff[sq_sel[1:0]], 8'd0})) - 33'(base_ff[sq_sel[1:0]]);
         end else begin
            cmd.b = 33'(rate_ff[2'(sq_sel - 3'd3)]);
         end
      end
   end

   gisd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .acc   (acc),
      .prod  (prod)
   );

   // Rounded step: floor((p + 32768) / 65536).
   logic signed [49:0] step_full;
   assign step_full = (signed'(prod) + 50'sd32768) >>> 16;

   // Head-rate sum is acc minus residual sum after all six squares.
   logic [63:0] hsq;
   logic        head_hit;
   assign hsq      = acc - rsq_ff;
   assign head_hit = hsq > 64'(head_ff) * 64'(head_ff);

   logic [63:0] enter_sq, exit_sq;
   assign enter_sq = 64'({enter_ff, 8'd0}) * 64'({enter_ff, 8'd0});
   assign exit_sq  = 64'({exit_ff, 8'd0}) * 64'({exit_ff, 8'd0});

   logic [3:0] need;
   assign need = (needed_ff < 4'(MinImpulses)) ? 4'(MinImpulses) : needed_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_mode && bvalid_ff) begin
               state_in = ST_STEP;
               cnt_in   = '0;
            end else if (accept) begin
               state_in = ST_RSP;
            end
         end
         ST_STEP: state_in = ST_UPD;
         ST_UPD: begin
            if (cnt_ff == 4'd2) begin
               state_in = ST_SQ;
               cnt_in   = '0;
            end else begin
               state_in = ST_STEP;
               cnt_in   = cnt_ff + 4'd1;
            end
         end
         ST_SQ: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd5) state_in = ST_DEC;
         end
         ST_DEC: state_in = ST_RSP;
         ST_RSP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         enter_ff <= 15'd480;  exit_ff <= 15'd240;  head_ff <= 15'd1600;
         imp_min_ff <= 16'd20; imp_max_ff <= 16'd200;
         gap_min_ff <= 16'd100; gap_max_ff <= 16'd800;
         needed_ff <= 4'd2;
         bvalid_ff <= 1'b0; in_imp_ff <= 1'b0; recent_ff <= 1'b0;
         mgate_ff <= 1'b0; cgate_ff <= 1'b0;
         prior_ff <= '0; imp_start_ff <= '0; seq_last_ff <= '0;
         recent_t_ff <= '0; mtime_ff <= '0; ctime_ff <= '0;
         seq_cnt_ff <= '0; imp_total_ff <= '0; click_total_ff <= '0;
         click_ff <= 1'b0;
         for (int k = 0; k < 3; k++) base_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENTER:   enter_ff   <= csr_data[14:0];
               CSR_EXIT:    exit_ff    <= csr_data[14:0];
               CSR_HEAD:    head_ff    <= csr_data[14:0];
               CSR_IMP_MIN: imp_min_ff <= csr_data[15:0];
               CSR_IMP_MAX: imp_max_ff <= csr_data[15:0];
               CSR_GAP_MIN: gap_min_ff <= csr_data[15:0];
               CSR_GAP_MAX: gap_max_ff <= csr_data[15:0];
               CSR_NEEDED:  needed_ff  <= csr_data[3:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && accept) begin
            click_ff <= 1'b0;
            now_ff <= req_now_time;
            rate_ff[0] <= req_rate_x; rate_ff[1] <= req_rate_y; rate_ff[2] <= req_rate_z;
            alpha_ff <= alpha_tab[dt];
            if (req_mode) begin
               bvalid_ff <= 1'b0; in_imp_ff <= 1'b0; recent_ff <= 1'b0;
               mgate_ff <= 1'b0; cgate_ff <= 1'b0;
               prior_ff <= '0; imp_start_ff <= '0; seq_last_ff <= '0;
               recent_t_ff <= '0; mtime_ff <= '0; ctime_ff <= '0;
               seq_cnt_ff <= '0; imp_total_ff <= '0; click_total_ff <= '0;
               for (int k = 0; k < 3; k++) base_ff[k] <= '0;
            end else if (!bvalid_ff) begin
               // The first sample seeds the baseline and opens the motion gate.
               base_ff[0] <= {req_rate_x, 8'd0};
               base_ff[1] <= {req_rate_y, 8'd0};
               base_ff[2] <= {req_rate_z, 8'd0};
               bvalid_ff <= 1'b1;
               prior_ff  <= req_now_time;
               mgate_ff  <= 1'b1;
               mtime_ff  <= req_now_time;
            end else begin
               prior_ff <= req_now_time;
            end
         end
         if (state_ff == ST_UPD) begin
            base_ff[ax] <= base_ff[ax] + 24'(step_full);
         end
         if (state_ff == ST_SQ && cnt_ff == 4'd3) begin
            rsq_ff <= acc;
         end
         if (state_ff == ST_DEC) begin
            // Decision chain, in the order the gates apply. The sequence count
            // and the recent-impulse flag are worked out first and stored once.
            automatic logic [3:0] sc = seq_cnt_ff;
            automatic logic rec = recent_ff;
            automatic logic [31:0] dur = now_ff - imp_start_ff;
            automatic logic [31:0] gap = now_ff - seq_last_ff;
            automatic logic stop = 1'b0;
            if (head_hit) begin
               in_imp_ff <= 1'b0; sc = '0; seq_last_ff <= '0;
               mgate_ff <= 1'b1; mtime_ff <= now_ff;
               stop = 1'b1;
            end
            if (!stop && mgate_ff) begin
               if (now_ff - mtime_ff < 32'(HEAD_QUIET_MS)) stop = 1'b1;
               else mgate_ff <= 1'b0;
            end
            if (!stop && cgate_ff) begin
               if (now_ff - ctime_ff < 32'(CLICK_HOLDOFF_MS)) stop = 1'b1;
               else cgate_ff <= 1'b0;
            end
            if (!stop) begin
               if (sc != '0 && gap > 32'(gap_max_ff)) sc = '0;
               if (recent_ff && now_ff - recent_t_ff < 32'(IMPULSE_HOLDOFF_MS)) begin
                  stop = 1'b1;
               end else begin
                  rec = 1'b0;
               end
            end
            if (!stop) begin
               if (!in_imp_ff) begin
                  if (rsq_ff >= enter_sq) begin
                     in_imp_ff <= 1'b1; imp_start_ff <= now_ff;
                  end
               end else if (rsq_ff > exit_sq) begin
                  if (dur > 32'(imp_max_ff)) begin
                     in_imp_ff <= 1'b0; sc = '0; seq_last_ff <= '0;
                  end
               end else begin
                  in_imp_ff <= 1'b0;
                  if (dur < 32'(imp_min_ff) || dur > 32'(imp_max_ff)) begin
                     sc = '0;
                  end else begin
                     imp_total_ff <= imp_total_ff + 32'd1;
                     rec = 1'b1; recent_t_ff <= now_ff;
                     if (sc != '0 && (gap < 32'(gap_min_ff) || gap > 32'(gap_max_ff)))
                        sc = '0;
                     sc = sc + 4'd1;
                     if (sc < need) begin
                        seq_last_ff <= now_ff;
                     end else begin
                        sc = '0; seq_last_ff <= '0;
                        cgate_ff <= 1'b1; ctime_ff <= now_ff;
                        click_total_ff <= click_total_ff + 32'd1;
                        click_ff <= 1'b1;
                     end
                  end
               end
            end
            seq_cnt_ff <= sc;
            recent_ff  <= rec;
         end
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while a result is held");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_click))
      else $error("result dropped while stalled");
   a_click_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_click |-> rsp_click_count != '0)
      else $error("click with zero click count");
endmodule
